[hdl/iplpm_pkg.sv]
// Shared types and constants of the IPv4 longest-prefix route lookup.
// No dependencies.
package iplpm_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned PrefixW = 6;
  localparam int unsigned PortW   = 8;
  localparam int unsigned CountW  = 5;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef struct packed {
    logic               hit;
    logic [PrefixW-1:0] prefix;
    logic [PortW-1:0]   port;
  } cand_t;

  // lo comes from the lower entry indexes; it keeps ties
  function automatic cand_t cand_pick(cand_t lo, cand_t hi);
    cand_t res;
    res = lo;
    if (hi.hit && (!lo.hit || (hi.prefix > lo.prefix))) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

[hdl/iplpm_req_if.sv]
// Request, response and register-write channels of the route lookup.
// Depends on iplpm_pkg.
interface iplpm_req_if import iplpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [AddrW-1:0]   dest_addr;
  logic [IndexW-1:0]  entry_index;
  logic [AddrW-1:0]   entry_mask;
  logic [AddrW-1:0]   entry_net;
  logic [PrefixW-1:0] entry_prefix;
  logic [PortW-1:0]   entry_port;

  modport source (output valid, kind, dest_addr, entry_index, entry_mask, entry_net,
                  entry_prefix, entry_port, input ready);
  modport sink   (input valid, kind, dest_addr, entry_index, entry_mask, entry_net,
                  entry_prefix, entry_port, output ready);
endinterface

interface iplpm_rsp_if import iplpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [PortW-1:0] out_port;

  modport source (output valid, found, out_port, input ready);
  modport sink   (input valid, found, out_port, output ready);
endinterface

interface iplpm_cfg_if import iplpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hdl/ipv4_longest_prefix_route_lookup_top.sv]
// IPv4 longest-prefix route lookup, top level.
// Requests enter on req (lookup or route write), results leave on rsp, one per request.
// cfg writes route_count, the number of entries scanned from index zero.
// Pipeline: the match stage checks all entries in parallel, then the pairwise
// best-prefix selection tree adds one register level per tree level.
// Throughput: one request per cycle while rsp is not stalled; every stage is a register.
// A route write takes effect for all later requests and answers found 0.
// Stall: when rsp.valid is high and rsp.ready low, the whole pipeline holds
// and req.ready drops; nothing is lost or repeated.
// Reset: pipeline valid bits and route_count clear; table contents stay
// undefined until written. cfg.ready is always high.
// Depends on iplpm_pkg, the channel interfaces, iplpm_table and iplpm_tree.
module ipv4_longest_prefix_route_lookup_top import iplpm_pkg::*; #(
  parameter int unsigned ROUTE_ENTRIES = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  iplpm_req_if.sink   req,
  iplpm_rsp_if.source rsp,
  iplpm_cfg_if.sink   cfg
);

  logic [CountW-1:0]         route_count_q;
  logic                      en;
  cand_t [ROUTE_ENTRIES-1:0] leaf;
  logic                      leaf_valid;
  cand_t                     root;
  logic                      root_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_count_q <= '0;
    end else if (cfg.valid && cfg.ready) begin
      route_count_q <= cfg.data;
    end
  end

  assign cfg.ready = 1'b1;
  assign en        = !root_valid || rsp.ready;
  assign req.ready = en;

  iplpm_table #(.N(ROUTE_ENTRIES)) u_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (req.valid),
    .kind_i         (req.kind),
    .dest_addr_i    (req.dest_addr),
    .entry_index_i  (req.entry_index),
    .entry_mask_i   (req.entry_mask),
    .entry_net_i    (req.entry_net),
    .entry_prefix_i (req.entry_prefix),
    .entry_port_i   (req.entry_port),
    .count_i        (route_count_q),
    .leaf_o         (leaf),
    .valid_o        (leaf_valid)
  );

  iplpm_tree #(.N(ROUTE_ENTRIES)) u_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .leaf_i  (leaf),
    .valid_i (leaf_valid),
    .root_o  (root),
    .valid_o (root_valid)
  );

  assign rsp.valid    = root_valid;
  assign rsp.found    = root.hit;
  assign rsp.out_port = root.port;

  a_miss_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.found) |-> (rsp.out_port == '0))
    else $error("miss response with nonzero port");

  a_ready_follows_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready == (!rsp.valid || rsp.ready))
    else $error("request ready disagrees with output stall");

  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg.valid && cfg.ready) |=> $stable(route_count_q))
    else $error("route count changed without a write");

  a_write_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready && (req.kind == KIND_WRITE)) |=> !leaf[0].hit)
    else $error("route write produced a match");

endmodule

[hdl/iplpm_table.sv]
// Route table storage and the parallel match stage, one registered candidate per entry.
// Depends on iplpm_pkg.
module iplpm_table import iplpm_pkg::*; #(
  parameter int unsigned N = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               kind_i,
  input  logic [AddrW-1:0]   dest_addr_i,
  input  logic [IndexW-1:0]  entry_index_i,
  input  logic [AddrW-1:0]   entry_mask_i,
  input  logic [AddrW-1:0]   entry_net_i,
  input  logic [PrefixW-1:0] entry_prefix_i,
  input  logic [PortW-1:0]   entry_port_i,
  input  logic [CountW-1:0]  count_i,
  output cand_t [N-1:0]      leaf_o,
  output logic               valid_o
);

  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

  logic [AddrW-1:0]   mask_q   [N];
  logic [AddrW-1:0]   net_q    [N];
  logic [PrefixW-1:0] prefix_q [N];
  logic [PortW-1:0]   port_q   [N];

  cand_t [N-1:0] leaf_q;
  logic          valid_q;
  logic          wr_en;
  logic [IW-1:0] wr_idx;

  assign wr_idx = IW'(entry_index_i);
  assign wr_en  = en_i && valid_i && (kind_i == KIND_WRITE) && (int'(entry_index_i) < N);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mask_q[wr_idx]   <= entry_mask_i;
      net_q[wr_idx]    <= entry_net_i;
      prefix_q[wr_idx] <= entry_prefix_i;
      port_q[wr_idx]   <= entry_port_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_entry
    logic hit;
    assign hit = (kind_i == KIND_LOOKUP) && (int'(count_i) > i) &&
                 ((dest_addr_i & mask_q[i]) == net_q[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        leaf_q[i].hit    <= hit;
        leaf_q[i].prefix <= prefix_q[i];
        leaf_q[i].port   <= hit ? port_q[i] : '0;
      end
    end
  end

  assign leaf_o  = leaf_q;
  assign valid_o = valid_q;

endmodule

[hdl/iplpm_tree.sv]
// Pipelined selection tree: one register level per pairwise best-prefix pick.
// Depends on iplpm_pkg.
module iplpm_tree import iplpm_pkg::*; #(
  parameter int unsigned N = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  cand_t [N-1:0] leaf_i,
  input  logic          valid_i,
  output cand_t         root_o,
  output logic          valid_o
);

  localparam int unsigned LEVELS = (N > 1) ? $clog2(N) : 0;
  localparam int unsigned P      = 1 << LEVELS;

  cand_t leaf_w [P];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_used
      assign leaf_w[j] = leaf_i[j];
    end else begin : g_pad
      assign leaf_w[j] = '0;
    end
  end

  if (LEVELS == 0) begin : g_flat
    assign root_o  = leaf_w[0];
    assign valid_o = valid_i;
  end else begin : g_deep
    cand_t             node_q [1:P-1];
    logic [LEVELS-1:0] valid_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= '0;
      end else if (en_i) begin
        valid_q <= LEVELS'({valid_q, valid_i});
      end
    end

    for (genvar k = 1; k < P; k++) begin : g_node
      cand_t lo;
      cand_t hi;
      if (2 * k >= P) begin : g_from_leaf
        assign lo = leaf_w[2*k-P];
        assign hi = leaf_w[2*k+1-P];
      end else begin : g_from_node
        assign lo = node_q[2*k];
        assign hi = node_q[2*k+1];
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          node_q[k] <= cand_pick(lo, hi);
        end
      end
    end

    assign root_o  = node_q[1];
    assign valid_o = valid_q[LEVELS-1];
  end

endmodule
